// ===== design/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
// Holds the opcode set and the command/status structs between controller and datapath.
// No dependencies.
package bra_pkg;

  // Operation codes carried by each transaction
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TEST  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_SET   = 2'd3
  } opcode_t;

  // Map geometry and register reset value
  localparam int unsigned   BYTE_W      = 8;
  localparam logic [7:0]    BIU_RESET   = 8'd128;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // latch transaction fields, rewind address, zero results
    logic init_wr;  // reset sweep: zero byte at address, advance
    logic clr_wr;   // clear-all sweep: zero byte at address if in use, advance
    logic rd_byte;  // read the byte holding bit_index
    logic modify;   // evaluate test, write back set
    logic scan;     // issue next scan read and evaluate returned byte
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic init_last;  // reset sweep on its final byte
    logic clr_last;   // clear-all sweep on its final byte
    logic scan_ok;    // run length is non-zero and fits the bits in use
    logic scan_done;  // run found or final byte evaluated
  } sts_t;

endpackage

// ===== design/bra_datapath.sv =====
// Datapath of the bitmap run allocator: map memory, address counter, scan logic,
// configuration register and result registers.
// Depends on bra_pkg.
module bra_datapath
  import bra_pkg::*;
#(
  parameter int MAP_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  opcode_t     in_opcode,
  input  logic [9:0]  in_bit_index,
  input  logic        in_set_value,
  input  logic [10:0] in_run_length,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_found,
  output logic [9:0]  out_start_index,
  output logic        out_bit_value,
  output logic        out_index_error
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;
  localparam logic [8:0]    ActCap   = (MAP_BYTES > 255) ? 9'd255 : 9'(MAP_BYTES);
  localparam logic [CW-1:0] InitLast = CW'(MAP_BYTES - 1);

  logic [7:0]        biu_r;
  logic [8:0]        act;
  logic [CW-1:0]     act_w;
  logic [11:0]       nbits;

  opcode_t           op_r;
  logic [9:0]        idx_r;
  logic              val_r;
  logic [10:0]       len_r;

  logic [CW-1:0]     addr_r, addr_nxt;
  logic              issue;
  logic              rd_vld_r;
  logic [7:0]        rd_pos_r;
  logic [10:0]       run_r;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] usage_map_r [MAP_BYTES];

  logic              we, re;
  logic [AW-1:0]     waddr, raddr, byte_addr;
  logic [BYTE_W-1:0] wdata;

  logic              idx_ok;
  logic [10:0]       run_v;
  logic              hit;
  logic [2:0]        hit_bit;
  logic [11:0]       start_calc;
  logic              scan_last;

  logic              found_r, bitv_r, err_r;
  logic [9:0]        start_r;

  // Configuration register: bytes in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r <= BIU_RESET;
    end else if (cfg_wr_en) begin
      biu_r <= cfg_wr_data;
    end
  end

  // Clamp to the map size; bits in use are eight per byte
  assign act   = ({1'b0, biu_r} > ActCap) ? ActCap : {1'b0, biu_r};
  assign act_w = CW'(act);
  assign nbits = {act, 3'b000};

  // Latch transaction fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      idx_r <= in_bit_index;
      val_r <= in_set_value;
      len_r <= in_run_length;
    end
  end

  assign idx_ok    = ({2'b00, idx_r} < nbits);
  assign byte_addr = idx_ok ? AW'(idx_r[9:3]) : '0;
  assign issue     = cmd.scan && (addr_r < act_w);

  // Address counter for sweeps and scan
  always_comb begin
    addr_nxt = addr_r;
    if (cmd.load) begin
      addr_nxt = '0;
    end else if (cmd.init_wr || cmd.clr_wr || issue) begin
      addr_nxt = addr_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      addr_r   <= addr_nxt;
      rd_vld_r <= issue;
    end
  end

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = addr_r[AW-1:0];
    wdata = '0;
    re    = 1'b0;
    raddr = byte_addr;
    if (cmd.init_wr) begin
      we = 1'b1;
    end else if (cmd.clr_wr && (addr_r < act_w)) begin
      we = 1'b1;
    end else if (cmd.modify && (op_r == OP_SET) && idx_ok) begin
      we    = 1'b1;
      waddr = byte_addr;
      wdata = rdata_r;
      wdata[idx_r[2:0]] = val_r;
    end
    if (cmd.rd_byte) begin
      re = 1'b1;
    end else if (issue) begin
      re    = 1'b1;
      raddr = addr_r[AW-1:0];
    end
  end

  // Map storage, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      usage_map_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= usage_map_r[raddr];
    end
  end

  // Track which byte the read data belongs to
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_pos_r <= addr_r[7:0];
    end
  end

  // Walk the eight bits of the returned byte, extending the free run
  always_comb begin
    run_v   = run_r;
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      if (rdata_r[b]) begin
        run_v = '0;
      end else begin
        run_v = run_v + 11'd1;
      end
      if (!hit && (run_v == len_r)) begin
        hit     = 1'b1;
        hit_bit = 3'(b);
      end
    end
  end

  assign start_calc = {1'b0, rd_pos_r, hit_bit} + 12'd1 - {1'b0, len_r};
  assign scan_last  = ({1'b0, rd_pos_r} == (act - 9'd1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_r <= '0;
    end else if (cmd.scan && rd_vld_r) begin
      run_r <= run_v;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_r <= 1'b0;
      start_r <= '0;
      bitv_r  <= 1'b0;
      err_r   <= 1'b0;
    end else if (cmd.modify) begin
      bitv_r <= (op_r == OP_TEST) && idx_ok && rdata_r[idx_r[2:0]];
      err_r  <= !idx_ok;
    end else if (cmd.scan && rd_vld_r && hit) begin
      found_r <= 1'b1;
      start_r <= start_calc[9:0];
    end
  end

  assign sts.init_last = (addr_r == InitLast);
  assign sts.clr_last  = ((addr_r + CW'(1)) >= act_w);
  assign sts.scan_ok   = (len_r != 11'd0) && ({1'b0, len_r} <= nbits);
  assign sts.scan_done = rd_vld_r && (hit || scan_last);

  assign out_found       = found_r;
  assign out_start_index = start_r;
  assign out_bit_value   = bitv_r;
  assign out_index_error = err_r;

`ifndef ASSERT_OFF
  // A scan never modifies the map
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !we) else $error("map written during scan");

  // An out-of-range test or set leaves the map unchanged
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.modify && !idx_ok) |-> !we) else $error("map written on index error");

  // A new transaction rewinds the address and the free run
  a_load_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> ((addr_r == '0) && (run_r == '0))) else $error("load did not rewind");
`endif

endmodule

// ===== design/bra_ctrl.sv =====
// Controller of the bitmap run allocator: one-hot state machine sequencing
// reset sweep, clear-all, test/set and scan. Depends on bra_pkg.
module bra_ctrl
  import bra_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  opcode_t in_opcode,
  input  sts_t    sts,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid
);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CLEAR = 6'b000100,
    ST_READ  = 6'b001000,
    ST_MOD   = 6'b010000,
    ST_SCAN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r, done_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_opcode)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_SCAN:  state_nxt = ST_SCAN;
            default:  state_nxt = ST_READ;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end
      end
      ST_READ: begin
        cmd.rd_byte = 1'b1;
        state_nxt   = ST_MOD;
      end
      ST_MOD: begin
        cmd.modify = 1'b1;
        state_nxt  = ST_IDLE;
        done_nxt   = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (!sts.scan_ok || sts.scan_done) begin
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = done_r;

`ifndef ASSERT_OFF
  // The strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("result strobe held");

  // A result is shown only once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == ST_IDLE)) else $error("result strobe while busy");

  // An accepted transaction always leaves idle
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (state_r == ST_IDLE)) |=> busy) else $error("transaction not started");
`endif

endmodule

// ===== design/bitmap_run_allocator_core.sv =====
// Bitmap first-fit allocator. Test/set reads the addressed byte, then evaluates and writes it back;
// clear-all zeroes each byte in use; a scan with a rejected length finds nothing, else it walks the bytes in use
// until a run is found or the final byte is evaluated (the scan walks one map byte a cycle out of the map
// memory). One transaction at a time; busy falls as the result shows, so the next start is taken in the strobe cycle.
// After reset the map is swept to zero with busy high; the receiver cannot stall.
// Depends on bra_pkg, bra_ctrl, bra_datapath.
module bitmap_run_allocator_core
  import bra_pkg::*;
#(
  parameter int MAP_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_bit_index,
  input  logic        in_set_value,
  input  logic [10:0] in_run_length,
  output logic        out_valid,
  output logic        out_found,
  output logic [9:0]  out_start_index,
  output logic        out_bit_value,
  output logic        out_index_error
);

  cmd_t    cmd;
  sts_t    sts;
  opcode_t opcode;

  assign opcode = opcode_t'(in_opcode);

  // Sequence each transaction
  bra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Map storage and scan
  bra_datapath #(
    .MAP_BYTES (MAP_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_opcode       (opcode),
    .in_bit_index    (in_bit_index),
    .in_set_value    (in_set_value),
    .in_run_length   (in_run_length),
    .cmd             (cmd),
    .sts             (sts),
    .out_found       (out_found),
    .out_start_index (out_start_index),
    .out_bit_value   (out_bit_value),
    .out_index_error (out_index_error)
  );

endmodule
